// File: sv/limit_order_book_matcher_defines.svh
// Assertion macros for the limit order book matcher.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LOBM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LOBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lobm_pkg.sv
// Shared constants and types for the limit order book matcher.
// No dependencies.
package lobm_pkg;

    localparam int NUM_BOOKS   = 4;
    localparam int ORDER_SLOTS = 32;
    localparam int TOTAL_SLOTS = NUM_BOOKS * ORDER_SLOTS;
    localparam int SLOT_W      = $clog2(ORDER_SLOTS);
    localparam int ADDR_W      = $clog2(TOTAL_SLOTS);

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 3;

    // Result kinds carried on m_tuser.
    localparam logic [2:0] KIND_FILL    = 3'd0;
    localparam logic [2:0] KIND_RESTED  = 3'd1;
    localparam logic [2:0] KIND_FILLED  = 3'd2;
    localparam logic [2:0] KIND_REJECT  = 3'd3;
    localparam logic [2:0] KIND_DROPPED = 3'd4;

    // One resting order as held in slot storage.
    typedef struct packed {
        logic               side;
        logic signed [15:0] price;
        logic [23:0]        qty;
        logic [47:0]        stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

// File: sv/lobm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/limit_order_book_matcher.sv
// Limit order book matcher top level: order intake, slot scan sequencer and results.
// Depends on lobm_pkg, lobm_ram and limit_order_book_matcher_defines.svh.
//
// One order request enters on the s_ channel; its results leave on the m_ channel.
// Each order yields zero or more fill results (m_tlast low) and one final result
// (m_tlast high) whose kind is on m_tuser: rested, fully filled, rejected or dropped.
// The block takes one order at a time; s_tready is low while an order is in work.
// A rejected order skips the scan and goes straight to its final result. Every
// matching pass scans all ORDER_SLOTS slots of the order's book through the one
// read port of the slot RAM, one slot a cycle, and one shared compare unit keeps
// the best crossing slot; a decide step then issues its fill, and a new pass
// follows while quantity remains.
// Results pass through an output register, so the next order may be taken while
// the final result of the previous one still waits. If the receiver stalls, the
// sequencer holds before loading the next result and nothing is lost.
// Reset clears all slot valid bits at once (all books empty) and the control state;
// no clearing pass is needed.
`include "limit_order_book_matcher_defines.svh"

module limit_order_book_matcher
    import lobm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // book_index[1:0], side[2], order_style[4:3], limit_price[20:5],
    // order_quantity[44:21], order_time[92:45], zero pad[95:93]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // fill_price[15:0], fill_quantity[39:16], resting_slot[45:40],
    // remaining_quantity[69:46], zero pad[71:70]
    output logic [M_TDATA_W-1:0] m_tdata,
    // result_kind[2:0]
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    // Input field decode.
    logic [1:0]         in_book;
    logic               in_side;
    logic [1:0]         in_style;
    logic signed [15:0] in_price;
    logic [23:0]        in_qty;
    logic [47:0]        in_time;
    logic               in_reject;

    assign in_book   = s_tdata[1:0];
    assign in_side   = s_tdata[2];
    assign in_style  = s_tdata[4:3];
    assign in_price  = s_tdata[20:5];
    assign in_qty    = s_tdata[44:21];
    assign in_time   = s_tdata[92:45];
    assign in_reject = (in_qty == 24'd0) || in_price[15] || in_style[1]
                       || (32'(in_book) >= 32'(NUM_BOOKS));

    // Control and order registers.
    state_t             state_reg, state_next;
    logic [1:0]         book_reg;
    logic               side_reg;
    logic signed [15:0] price_reg;
    logic [23:0]        rem_reg, rem_next;
    logic [47:0]        time_reg;
    logic               reject_reg;
    logic [SLOT_W:0]    issue_cnt_reg;
    logic               rd_vld_reg;
    logic [SLOT_W-1:0]  rd_idx_reg;
    logic               best_found_reg;
    logic [SLOT_W-1:0]  best_idx_reg;
    entry_t             best_reg;
    logic [TOTAL_SLOTS-1:0] valid_reg;

    // Output register.
    logic               m_tvalid_reg;
    logic [2:0]         out_kind_reg;
    logic signed [15:0] out_price_reg;
    logic [23:0]        out_qty_reg;
    logic [5:0]         out_slot_reg;
    logic [23:0]        out_rem_reg;
    logic               out_last_reg;
    logic               out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_rem_reg, out_slot_reg, out_qty_reg, out_price_reg};

    // Slot addressing within the order's book.
    logic [ADDR_W-1:0]      base_addr;
    logic [ORDER_SLOTS-1:0] book_valid;

    assign base_addr = ADDR_W'(32'(book_reg) * 32'(ORDER_SLOTS));

    always_comb begin
        for (int i = 0; i < ORDER_SLOTS; i++) begin
            book_valid[i] = valid_reg[base_addr + ADDR_W'(i)];
        end
    end

    // Lowest free slot of the book.
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
            if (!book_valid[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Slot storage.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    entry_t            ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;

    assign ram_raddr = base_addr + ADDR_W'(issue_cnt_reg[SLOT_W-1:0]);
    assign ram_rdata = entry_t'(ram_rdata_raw);

    lobm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TOTAL_SLOTS)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata_raw)
    );

    // Shared compare unit: does the slot just read cross and beat the current best?
    logic cand_cross;
    logic cand_better;
    logic cand_take;

    always_comb begin
        cand_cross = book_valid[rd_idx_reg] && (ram_rdata.side != side_reg)
                     && (side_reg ? (ram_rdata.price >= price_reg)
                                  : (ram_rdata.price <= price_reg));
        if (!best_found_reg) begin
            cand_better = 1'b1;
        end else if (ram_rdata.price != best_reg.price) begin
            cand_better = side_reg ? (ram_rdata.price > best_reg.price)
                                   : (ram_rdata.price < best_reg.price);
        end else begin
            cand_better = ram_rdata.stamp < best_reg.stamp;
        end
        cand_take = rd_vld_reg && cand_cross && cand_better;
    end

    // Fill arithmetic on the chosen slot.
    logic [23:0] fill_qty;
    logic [23:0] slot_left;

    assign fill_qty  = (rem_reg < best_reg.qty) ? rem_reg : best_reg.qty;
    assign slot_left = best_reg.qty - fill_qty;

    logic scan_done;
    assign scan_done = (issue_cnt_reg == (SLOT_W + 1)'(ORDER_SLOTS)) && !rd_vld_reg;

    // Sequencer next state, storage writes and result load.
    logic               out_load;
    logic [2:0]         out_kind;
    logic signed [15:0] out_price;
    logic [23:0]        out_qty;
    logic [5:0]         out_slot;
    logic [23:0]        out_rem;
    logic               out_last;
    logic               scan_start;
    logic               valid_set;
    logic               valid_clr;

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        out_load   = 1'b0;
        out_kind   = KIND_FILL;
        out_price  = '0;
        out_qty    = '0;
        out_slot   = '0;
        out_rem    = '0;
        out_last   = 1'b0;
        scan_start = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = base_addr + ADDR_W'(best_idx_reg);
        ram_wdata  = best_reg;
        valid_set  = 1'b0;
        valid_clr  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = in_reject ? ST_FINISH : ST_SCAN;
                    scan_start = 1'b1;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = best_found_reg ? ST_DECIDE : ST_FINISH;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    rem_next      = rem_reg - fill_qty;
                    ram_we        = 1'b1;
                    ram_wdata.qty = slot_left;
                    valid_clr     = (slot_left == 24'd0);
                    out_load      = 1'b1;
                    out_kind      = KIND_FILL;
                    out_price     = best_reg.price;
                    out_qty       = fill_qty;
                    out_slot      = 6'(best_idx_reg);
                    out_rem       = rem_next;
                    if (rem_next == 24'd0) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                        scan_start = 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                    if (reject_reg) begin
                        out_kind = KIND_REJECT;
                        out_rem  = rem_reg;
                    end else if (rem_reg == 24'd0) begin
                        out_kind = KIND_FILLED;
                    end else if (free_found) begin
                        out_kind  = KIND_RESTED;
                        out_slot  = 6'(free_idx);
                        out_rem   = rem_reg;
                        ram_we    = 1'b1;
                        ram_waddr = base_addr + ADDR_W'(free_idx);
                        ram_wdata = '{side: side_reg, price: price_reg,
                                      qty: rem_reg, stamp: time_reg};
                        valid_set = 1'b1;
                    end else begin
                        out_kind = KIND_DROPPED;
                        out_rem  = rem_reg;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            rd_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            issue_cnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (valid_set) begin
                valid_reg[base_addr + ADDR_W'(free_idx)] <= 1'b1;
            end
            if (valid_clr) begin
                valid_reg[base_addr + ADDR_W'(best_idx_reg)] <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // Scan issue counter and read pipeline.
            rd_vld_reg <= (state_reg == ST_SCAN)
                          && (issue_cnt_reg < (SLOT_W + 1)'(ORDER_SLOTS));
            if (scan_start) begin
                issue_cnt_reg  <= '0;
                best_found_reg <= 1'b0;
            end else begin
                if ((state_reg == ST_SCAN)
                    && (issue_cnt_reg < (SLOT_W + 1)'(ORDER_SLOTS))) begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (cand_take) begin
                    best_found_reg <= 1'b1;
                end
            end
        end
    end

    // Order, best-slot and result payload registers.
    always_ff @(posedge aclk) begin
        rd_idx_reg <= issue_cnt_reg[SLOT_W-1:0];
        if (s_tvalid && s_tready) begin
            book_reg   <= in_book;
            side_reg   <= in_side;
            price_reg  <= in_price;
            rem_reg    <= in_qty;
            time_reg   <= in_time;
            reject_reg <= in_reject;
        end else begin
            rem_reg <= rem_next;
        end
        if (cand_take && !scan_start) begin
            best_idx_reg <= rd_idx_reg;
            best_reg     <= ram_rdata;
        end
        if (out_load) begin
            out_kind_reg  <= out_kind;
            out_price_reg <= out_price;
            out_qty_reg   <= out_qty;
            out_slot_reg  <= out_slot;
            out_rem_reg   <= out_rem;
            out_last_reg  <= out_last;
        end
    end

    // Checks on the sequencer and result coding.
    `LOBM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "order taken while busy")
    `LOBM_ASSERT_SAME(a_fill_not_last, m_tvalid && (m_tuser == KIND_FILL), !m_tlast && (m_tdata[39:16] != 24'd0), "bad fill result")
    `LOBM_ASSERT_SAME(a_final_is_last, m_tvalid && (m_tuser != KIND_FILL), m_tlast, "final result without last")

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the limit order book matcher.
// Depends on lobm_pkg and limit_order_book_matcher; an order-book predictor checks each result.
`timescale 1ns / 1ps

module tb;
    import lobm_pkg::*;

    // One expected result of an order.
    typedef struct {
        logic [2:0]         kind;
        logic signed [15:0] price;
        logic [23:0]        qty;
        logic [5:0]         slot;
        logic [23:0]        remain;
        logic               last;
    } outcome_t;

    // Book predictor and store of pending outcomes.
    class book_scoreboard;
        bit                 live[TOTAL_SLOTS];
        bit                 side_of[TOTAL_SLOTS];
        logic signed [15:0] price_of[TOTAL_SLOTS];
        logic [23:0]        qty_of[TOTAL_SLOTS];
        logic [47:0]        stamp_of[TOTAL_SLOTS];
        outcome_t           pending[$];
        int                 errors;

        function void push(logic [2:0] k, logic signed [15:0] p, logic [23:0] q,
                           logic [5:0] s, logic [23:0] r, logic l);
            outcome_t o;
            o.kind = k; o.price = p; o.qty = q; o.slot = s; o.remain = r; o.last = l;
            pending.insert(pending.size(), o);
        endfunction

        // Work out every result of one accepted order and update the books.
        function void note_order(logic [95:0] d);
            logic [1:0]         bk;
            bit                 sd;
            logic [1:0]         sty;
            logic signed [15:0] px;
            logic [23:0]        rem;
            logic [23:0]        f;
            logic [47:0]        ts;
            int                 base;
            int                 best;
            int                 hole;
            bit                 hit;
            bit                 wins;
            bk = d[1:0]; sd = d[2]; sty = d[4:3]; px = d[20:5];
            rem = d[44:21]; ts = d[92:45];
            if (rem == 0 || px < 0 || sty > 1 || bk >= NUM_BOOKS) begin
                push(KIND_REJECT, 0, 0, 0, rem, 1);
                return;
            end
            base = bk * ORDER_SLOTS;
            while (rem > 0) begin
                best = -1;
                for (int i = base; i < base + ORDER_SLOTS; i++) begin
                    if (!live[i] || side_of[i] == sd) continue;
                    hit = (sd == 0) ? (price_of[i] <= px) : (price_of[i] >= px);
                    if (!hit) continue;
                    if (best < 0) wins = 1;
                    else if (price_of[i] != price_of[best])
                        wins = (sd == 0) ? (price_of[i] < price_of[best])
                                         : (price_of[i] > price_of[best]);
                    else wins = stamp_of[i] < stamp_of[best];
                    if (wins) best = i;
                end
                if (best < 0) break;
                f = (rem < qty_of[best]) ? rem : qty_of[best];
                rem -= f;
                qty_of[best] -= f;
                if (qty_of[best] == 0) live[best] = 0;
                push(KIND_FILL, price_of[best], f, 6'(best - base), rem, 0);
            end
            if (rem == 0) begin
                push(KIND_FILLED, 0, 0, 0, 0, 1);
                return;
            end
            hole = -1;
            for (int i = base; i < base + ORDER_SLOTS; i++)
                if (!live[i] && hole < 0) hole = i;
            if (hole < 0) begin
                push(KIND_DROPPED, 0, 0, 0, rem, 1);
                return;
            end
            live[hole] = 1; side_of[hole] = sd; price_of[hole] = px;
            qty_of[hole] = rem; stamp_of[hole] = ts;
            push(KIND_RESTED, 0, 0, 6'(hole - base), rem, 1);
        endfunction

        // Compare one delivered result with the oldest pending outcome.
        function void check_result(logic [2:0] k, logic [71:0] d, logic l);
            outcome_t o;
            if (pending.size() == 0) begin
                $error("unexpected result kind %0d", k);
                errors++;
                return;
            end
            o = pending.pop_front();
            if (k !== o.kind) begin
                $error("result_kind expected %0d actual %0d", o.kind, k); errors++;
            end
            if (d[15:0] !== o.price) begin
                $error("fill_price expected %0d actual %0d", o.price, $signed(d[15:0]));
                errors++;
            end
            if (d[39:16] !== o.qty) begin
                $error("fill_quantity expected %0d actual %0d", o.qty, d[39:16]); errors++;
            end
            if (d[45:40] !== o.slot) begin
                $error("resting_slot expected %0d actual %0d", o.slot, d[45:40]); errors++;
            end
            if (d[69:46] !== o.remain) begin
                $error("remaining_quantity expected %0d actual %0d", o.remain, d[69:46]);
                errors++;
            end
            if (d[71:70] !== 2'b00) begin
                $error("pad expected 0 actual %0d", d[71:70]); errors++;
            end
            if (l !== o.last) begin
                $error("last expected %0d actual %0d", o.last, l); errors++;
            end
        endfunction
    endclass

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    book_scoreboard board = new();
    bit  calm = 0;      // no idling in the last part of the run
    bit  hold_off = 0;  // long receiver stall request
    longint cycles = 0;

    limit_order_book_matcher dut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // Results are sampled at the rising edge.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tuser, m_tdata, m_tlast);
    end

    // Receiver: random stall bursts, plus one long stall on request.
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 0;
                repeat (3000) @(negedge aclk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 19);
                m_tready <= 0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1;
                if (!calm) begin
                    n = $urandom_range(1, 12);
                    repeat (n - 1) @(negedge aclk);
                end
            end
        end
    end

    function automatic logic [95:0] pack_order(logic [1:0] bk, bit sd, logic [1:0] sty,
                                               logic signed [15:0] px, logic [23:0] q,
                                               logic [47:0] ts);
        return {3'b000, ts, q, px, sty, sd, bk};
    endfunction

    // Offer one request and wait until it is taken; returns at the next falling edge.
    task automatic send_order(logic [95:0] d);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 19);
            s_tvalid <= 0;
            repeat (n) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        board.note_order(d);
        @(negedge aclk);
    endtask

    longint stamp = 1;

    // Well-formed limit order in a narrow price band so that books cross often, unless noisy scrambles its fields.
    task automatic send_random(bit noisy);
        logic [95:0] d;
        logic [23:0] q;
        q = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(1, 40));
        stamp += $urandom_range(0, 2);
        d = pack_order(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       2'($urandom_range(0, 1)), 16'($urandom_range(95, 105)), q,
                       48'(stamp));
        if ($urandom_range(0, 4) == 0) d[92:45] = 48'({$urandom, $urandom});
        if (noisy) d[92:0] = 93'({$urandom, $urandom, $urandom});
        send_order(d);
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: rejections and field extremes.
        send_order(pack_order(0, 0, 0, 100, 0, 0));
        send_order(pack_order(0, 0, 0, -1, 5, 0));
        send_order(pack_order(1, 1, 2, 100, 5, 0));
        send_order(pack_order(2, 0, 3, -32768, 24'hFFFFFF, 48'hFFFFFFFFFFFF));
        // Resting asks at equal price and time, then a crossing market buy.
        send_order(pack_order(0, 1, 0, 100, 10, 5));
        send_order(pack_order(0, 1, 0, 100, 10, 5));
        send_order(pack_order(0, 1, 0, 99, 3, 7));
        send_order(pack_order(0, 0, 1, 100, 15, 8));
        send_order(pack_order(0, 0, 0, 32767, 24'hFFFFFF, 48'hFFFFFFFFFFFF));
        send_order(pack_order(0, 1, 1, 0, 24'hFFFFFF, 9));
        send_order(pack_order(0, 1, 0, 0, 24'hFFFFFF, 10));
        // Fill book 3 entirely, then one drop, then a full sweep.
        for (int i = 0; i < ORDER_SLOTS; i++)
            send_order(pack_order(3, 1, 0, 16'(200 + (i % 5)), 2, 48'(100 - i)));
        send_order(pack_order(3, 1, 0, 300, 1, 1));
        send_order(pack_order(3, 0, 0, 210, 24'hFFFFFF, 2));

        // Long receiver stall while orders keep arriving.
        hold_off = 1;
        for (int i = 0; i < 6; i++) send_random(0);
        s_tvalid <= 0;
        wait (!hold_off);
        @(negedge aclk);

        for (int i = 0; i < 59; i++) begin
            if (i == 42) calm = 1;
            send_random($urandom_range(0, 9) == 0);
        end
        s_tvalid <= 0;

        wait (board.pending.size() == 0);
        repeat (200) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit.
    initial begin
        wait (cycles == 2000000);
        $display("DONE: errors detected");
        $finish;
    end
endmodule
